@@ sv/sjis_pkg.sv @@
// Shared types and constants of the Shift-JIS to Unicode converter.
// No dependencies; imported by every module of the block.
package sjis_pkg;

   localparam int TABLE_DEPTH = 8192;
   localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

   localparam int IDX_W  = 13;
   localparam int KEY_W  = 16;
   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 14;
   localparam int LIM_W  = 16;
   localparam int ENT_W  = KEY_W + CP_W;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IW     = 1;
   localparam int CSR_DW     = 16;

   localparam logic [CSR_IW-1:0] CSR_ENTRY_COUNT = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_CHAR_LIMIT  = 1'd1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_BYTE = 1'b1;

   localparam logic [CP_W-1:0]   REPLACEMENT = 21'h00FFFD;
   localparam logic [BYTE_W-1:0] LEAD_MARK   = 8'h80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  key;
      logic [TBL_CW-1:0] count;
   } srch_req_type;

   typedef struct packed {
      logic            done;
      logic            found;
      logic [CP_W-1:0] value;
   } srch_rsp_type;

   typedef struct packed {
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [ENT_W-1:0]  data;
   } tbl_wr_type;

   typedef struct packed {
      logic              re;
      logic [TBL_AW-1:0] addr;
   } tbl_rd_type;

endpackage

@@ sv/sjis_to_unicode_converter.sv @@
// Top level of the Shift-JIS to Unicode converter: string sequencer, config,
// output register. Depends on sjis_pkg, sjis_table and sjis_search.
//
// req channel: mode in tuser (0 load a table slot, 1 string byte), last_byte
// in tlast. A load writes one slot and finishes in the transfer cycle.
// rsp channel: code_point in tdata, last_char in tlast, not_found in tuser.
// csr channel: index 0 entry_count, index 1 char_limit; always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// A single-byte character or a replacement for a dangling lead byte passes
// through the result register (ST_PUSH) into the output register; the next
// byte is taken once it is there. A two-byte character runs the in-order
// search, one table read per cycle over n = min(entry_count, 8192) slots,
// and its result then takes the same path to the output register.
// Lead bytes, loads and skipped bytes keep req_tready high.
// req_tready is low from a byte that produces a result until that result is
// in the output register.
// If the receiver stalls, one result waits in the output register and one
// more is held in the sequencer; the block then stops taking items.
// Reset (synchronous) clears string state, sets entry_count 0 and char_limit
// 65535. Table contents are undefined until loaded.
module sjis_to_unicode_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [12:0] entry_index, [28:13] entry_key, [49:29] entry_value,
   // [57:50] byte_in, [63:58] zero
   input  logic [sjis_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,  // mode
   input  logic                             req_tlast,  // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [20:0] code_point, [23:21] zero
   output logic [sjis_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,  // not_found
   output logic                             rsp_tlast,  // last_char
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sjis_pkg::CSR_IW-1:0]      csr_index,
   input  logic [sjis_pkg::CSR_DW-1:0]      csr_data
);
   import sjis_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [LIM_W-1:0]  char_limit_ff, char_limit_in;
   logic [BYTE_W-1:0] held_lead_ff, held_lead_in;
   logic              lead_pending_ff, lead_pending_in;
   logic [LIM_W-1:0]  chars_out_ff, chars_out_in;
   logic              skipping_ff, skipping_in;
   logic              fin_ff, fin_in;
   logic              bzero_ff, bzero_in;
   logic [CP_W-1:0]   res_cp_ff, res_cp_in;
   logic              res_last_ff, res_last_in;
   logic              res_nf_ff, res_nf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   rsp_cp_ff, rsp_cp_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_nf_ff, rsp_nf_in;

   logic [IDX_W-1:0]  f_index;
   logic [KEY_W-1:0]  f_key;
   logic [CP_W-1:0]   f_value;
   logic [BYTE_W-1:0] f_byte;
   logic              acc;
   logic              skip;
   logic              form;
   logic [CP_W-1:0]   form_cp;
   logic              form_nf;
   logic              form_fin;
   logic              form_bzero;
   logic              form_last;
   logic [LIM_W-1:0]  chars_next;
   logic              move_out;

   srch_req_type      srch_req;
   srch_rsp_type      srch_rsp;
   tbl_wr_type        tbl_wr;
   tbl_rd_type        tbl_rd;
   logic [ENT_W-1:0]  tbl_rd_data;

   sjis_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_rd_data)
   );

   sjis_search u_search (
      .clock   (clock),
      .reset   (reset),
      .req     (srch_req),
      .rsp     (srch_rsp),
      .rd      (tbl_rd),
      .rd_data (tbl_rd_data)
   );

   assign f_index = req_tdata[12:0];
   assign f_key   = req_tdata[28:13];
   assign f_value = req_tdata[49:29];
   assign f_byte  = req_tdata[57:50];

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      entry_count_in = entry_count_ff;
      char_limit_in  = char_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: entry_count_in = csr_data[CNT_W-1:0];
            CSR_CHAR_LIMIT:  char_limit_in  = csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      held_lead_in    = held_lead_ff;
      lead_pending_in = lead_pending_ff;
      chars_out_in    = chars_out_ff;
      skipping_in     = skipping_ff;
      fin_in          = fin_ff;
      bzero_in        = bzero_ff;
      res_cp_in       = res_cp_ff;
      res_last_in     = res_last_ff;
      res_nf_in       = res_nf_ff;

      skip       = skipping_ff || (chars_out_ff >= char_limit_ff);
      form       = 1'b0;
      form_cp    = {{(CP_W-BYTE_W){1'b0}}, f_byte};
      form_nf    = 1'b0;
      form_fin   = req_tlast;
      form_bzero = (f_byte == '0);
      move_out   = 1'b0;

      tbl_wr.we   = 1'b0;
      tbl_wr.addr = TBL_AW'(f_index);
      tbl_wr.data = {f_key, f_value};

      srch_req.start = 1'b0;
      srch_req.key   = {held_lead_ff, f_byte};
      srch_req.count = (32'(entry_count_ff) > TABLE_DEPTH) ? TBL_CW'(TABLE_DEPTH)
                                                           : TBL_CW'(entry_count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_tuser == MODE_LOAD) begin
                  tbl_wr.we = (32'(f_index) < TABLE_DEPTH);
               end else if (skip) begin
                  if (req_tlast) begin
                     chars_out_in    = '0;
                     lead_pending_in = 1'b0;
                     skipping_in     = 1'b0;
                     held_lead_in    = '0;
                  end else begin
                     skipping_in     = 1'b1;
                     lead_pending_in = 1'b0;
                  end
               end else if (lead_pending_ff) begin
                  srch_req.start = 1'b1;
                  fin_in         = req_tlast;
                  bzero_in       = (f_byte == '0);
                  state_in       = ST_SEARCH;
               end else if ((f_byte & LEAD_MARK) != '0) begin
                  if (!req_tlast) begin
                     held_lead_in    = f_byte;
                     lead_pending_in = 1'b1;
                  end else begin
                     form    = 1'b1;
                     form_cp = REPLACEMENT;
                     form_nf = 1'b1;
                  end
               end else begin
                  form = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               form            = 1'b1;
               form_cp         = srch_rsp.found ? srch_rsp.value : REPLACEMENT;
               form_nf         = !srch_rsp.found;
               form_fin        = fin_ff;
               form_bzero      = bzero_ff;
               lead_pending_in = 1'b0;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               move_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      chars_next = chars_out_ff + 1'b1;
      form_last  = form_fin || ((form_cp == '0) && !form_nf && form_bzero) ||
                   (chars_next >= char_limit_ff);
      if (form) begin
         res_cp_in   = form_cp;
         res_nf_in   = form_nf;
         res_last_in = form_last;
         state_in    = ST_PUSH;
         if (form_fin) begin
            chars_out_in    = '0;
            lead_pending_in = 1'b0;
            skipping_in     = 1'b0;
            held_lead_in    = '0;
         end else begin
            chars_out_in = chars_next;
            skipping_in  = skipping_ff || form_last;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_nf_in    = rsp_nf_ff;
      if (move_out) begin
         rsp_valid_in = 1'b1;
         rsp_cp_in    = res_cp_ff;
         rsp_last_in  = res_last_ff;
         rsp_nf_in    = res_nf_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         char_limit_ff   <= '1;
         held_lead_ff    <= '0;
         lead_pending_ff <= 1'b0;
         chars_out_ff    <= '0;
         skipping_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         entry_count_ff  <= entry_count_in;
         char_limit_ff   <= char_limit_in;
         held_lead_ff    <= held_lead_in;
         lead_pending_ff <= lead_pending_in;
         chars_out_ff    <= chars_out_in;
         skipping_ff     <= skipping_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      fin_ff      <= fin_in;
      bzero_ff    <= bzero_in;
      res_cp_ff   <= res_cp_in;
      res_last_ff <= res_last_in;
      res_nf_ff   <= res_nf_in;
      rsp_cp_ff   <= rsp_cp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_nf_ff   <= rsp_nf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CP_W){1'b0}}, rsp_cp_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_nf_ff;

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      srch_rsp.done |-> state_ff == ST_SEARCH)
      else $error("search result outside search state");
   a_nf_is_replacement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nf_ff |-> rsp_cp_ff == REPLACEMENT)
      else $error("not-found result without replacement character");
   a_skip_no_lead: assert property (@(posedge clock) disable iff (reset)
      skipping_ff && state_ff == ST_IDLE |-> !lead_pending_ff)
      else $error("lead byte held while skipping");
   a_search_needs_lead: assert property (@(posedge clock) disable iff (reset)
      srch_req.start |-> lead_pending_ff && !skip)
      else $error("lookup started without a held lead byte");

endmodule

@@ sv/sjis_table.sv @@
// Key/code point pair memory: one write port, one registered read port.
// Depends on sjis_pkg.
module sjis_table (
   input  logic                      clock,
   input  sjis_pkg::tbl_wr_type      wr,
   input  sjis_pkg::tbl_rd_type      rd,
   output logic [sjis_pkg::ENT_W-1:0] rd_data
);
   import sjis_pkg::*;

   logic [ENT_W-1:0] mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.re) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sjis_search.sv @@
// In-order key search: walks the table one read per cycle, one shared compare.
// Depends on sjis_pkg; drives the read port of sjis_table.
module sjis_search (
   input  logic                       clock,
   input  logic                       reset,
   input  sjis_pkg::srch_req_type     req,
   output sjis_pkg::srch_rsp_type     rsp,
   output sjis_pkg::tbl_rd_type       rd,
   input  logic [sjis_pkg::ENT_W-1:0] rd_data
);
   import sjis_pkg::*;

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic [TBL_CW-1:0] rd_addr_ff, rd_addr_in;
   logic [TBL_CW-1:0] count_ff, count_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              done_ff, done_in;
   logic              found_ff, found_in;
   logic [CP_W-1:0]   value_ff, value_in;
   logic              issue;
   logic              match;

   always_comb begin
      issue = busy_ff && (rd_addr_ff < count_ff);
      match = pend_ff && (rd_data[ENT_W-1 -: KEY_W] == key_ff);

      busy_in    = busy_ff;
      pend_in    = 1'b0;
      rd_addr_in = rd_addr_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      value_in   = value_ff;

      if (req.start) begin
         key_in     = req.key;
         count_in   = req.count;
         rd_addr_in = '0;
         if (req.count == '0) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            found_in = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rd_addr_in = rd_addr_ff + TBL_CW'(issue);
         pend_in    = issue;
         if (match) begin
            busy_in  = 1'b0;
            pend_in  = 1'b0;
            done_in  = 1'b1;
            found_in = 1'b1;
            value_in = rd_data[CP_W-1:0];
         end else if (pend_ff && !issue) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            found_in = 1'b0;
         end
      end

      rd.re   = issue;
      rd.addr = rd_addr_ff[TBL_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      rd_addr_ff <= rd_addr_in;
      count_ff   <= count_in;
      key_ff     <= key_in;
      found_ff   <= found_in;
      value_ff   <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.found = found_ff;
   assign rsp.value = value_ff;

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rd_addr_ff <= count_ff)
      else $error("search address ran past entry count");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("search started while busy");
   a_pend_from_issue: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(issue))
      else $error("compare without a read issued");

endmodule
